>>> hw/rtl/strict_priority_drop_tail_queue_core_assert.svh
// Assertion macros shared by the queue core modules (clk / arst_n in scope).
`ifndef STRICT_PRIORITY_DROP_TAIL_QUEUE_CORE_ASSERT_SVH
`define STRICT_PRIORITY_DROP_TAIL_QUEUE_CORE_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SPDTQ_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("spdtq assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define SPDTQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spdtq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPDTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spdtq assertion failed");

`endif

>>> hw/rtl/spdtq_pkg.sv
// Package: sizes, opcodes, controller state and command types of the queue core.
package spdtq_pkg;

	localparam int NUM_CLASSES  = 4;
	localparam int FIFO_DEPTH   = 16;
	localparam int HANDLE_WIDTH = 32;

	localparam int CLASS_W = 2;
	localparam int CAP_W   = 5;
	localparam int PTR_W   = $clog2(FIFO_DEPTH);
	localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W  = $clog2(NUM_CLASSES * FIFO_DEPTH);

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic {
		S_IDLE,
		S_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic exec_enq;
		logic exec_deq;
	} cmd_t;

endpackage

>>> hw/rtl/strict_priority_drop_tail_queue_core.sv
// Top level of the strict priority drop-tail queue core.
// Four per-class packet FIFOs, 16 handles each, class 0 served first.
// Input channel (in_valid/in_ready): opcode, queue_class, packet_handle.
//   opcode enqueue appends the handle to its class unless the class holds
//   frame_capacity packets (0 = full depth), then it is dropped and flagged.
//   opcode dequeue pops the head of the lowest-numbered non-empty class.
// Output channel (out_valid/out_ready): one result beat per input beat.
// Config channel (cfg_valid/cfg_ready): writes frame_capacity, always ready;
//   write only while no item is in flight.
// Latency: result is valid the cycle after the input beat is taken.
// One item at a time: the controller holds each item from accept to
//   result handoff and takes no new item until its result is taken;
//   the packet store read is registered into the result.
// Receiver stall: the result is held and in_ready stays low until taken.
// Reset: all FIFOs empty, capacity 0, no result pending; no store clearing.
module strict_priority_drop_tail_queue_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic [spdtq_pkg::CLASS_W-1:0]      queue_class,
	input  logic [spdtq_pkg::HANDLE_WIDTH-1:0] packet_handle,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               enq_accepted,
	output logic                               enq_dropped,
	output logic                               deq_valid,
	output logic [spdtq_pkg::HANDLE_WIDTH-1:0] deq_packet,
	output logic [spdtq_pkg::CLASS_W-1:0]      deq_class,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [spdtq_pkg::CAP_W-1:0]        cfg_data
);

	spdtq_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	spdtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	spdtq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.queue_class   (queue_class),
		.packet_handle (packet_handle),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.enq_accepted  (enq_accepted),
		.enq_dropped   (enq_dropped),
		.deq_valid     (deq_valid),
		.deq_packet    (deq_packet),
		.deq_class     (deq_class)
	);

endmodule

>>> hw/rtl/spdtq_ctrl.sv
// Controller: takes one item, holds its result until taken, then returns to idle.
`include "strict_priority_drop_tail_queue_core_assert.svh"

module spdtq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	input  logic              out_ready,
	output logic              in_ready,
	output logic              out_valid,
	output spdtq_pkg::cmd_t   cmd
);

	spdtq_pkg::state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spdtq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			spdtq_pkg::S_IDLE: begin
				if (in_valid) state_nxt = spdtq_pkg::S_OUT;
			end
			spdtq_pkg::S_OUT: begin
				if (out_ready) state_nxt = spdtq_pkg::S_IDLE;
			end
			default: state_nxt = spdtq_pkg::S_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd.exec_enq = 1'b0;
		cmd.exec_deq = 1'b0;
		case (state_q)
			spdtq_pkg::S_IDLE: begin
				in_ready     = 1'b1;
				cmd.exec_enq = in_valid && (opcode == spdtq_pkg::OP_ENQ);
				cmd.exec_deq = in_valid && (opcode == spdtq_pkg::OP_DEQ);
			end
			spdtq_pkg::S_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	`SPDTQ_ASSERT_ALWAYS(a_one_item_at_a_time, !(in_ready && out_valid))
	`SPDTQ_ASSERT_ALWAYS(a_single_command, !(cmd.exec_enq && cmd.exec_deq))
	`SPDTQ_ASSERT_NEXT(a_beat_yields_result, in_valid && in_ready, out_valid)
	`SPDTQ_ASSERT_NEXT(a_result_taken_frees, out_valid && out_ready, in_ready)

endmodule

>>> hw/rtl/spdtq_datapath.sv
// Datapath: per-class pointers and counts, packet store, priority pick, result registers.
`include "strict_priority_drop_tail_queue_core_assert.svh"

module spdtq_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spdtq_pkg::cmd_t                    cmd,
	input  logic [spdtq_pkg::CLASS_W-1:0]      queue_class,
	input  logic [spdtq_pkg::HANDLE_WIDTH-1:0] packet_handle,
	input  logic                               cfg_we,
	input  logic [spdtq_pkg::CAP_W-1:0]        cfg_data,
	output logic                               enq_accepted,
	output logic                               enq_dropped,
	output logic                               deq_valid,
	output logic [spdtq_pkg::HANDLE_WIDTH-1:0] deq_packet,
	output logic [spdtq_pkg::CLASS_W-1:0]      deq_class
);

	localparam int NC = spdtq_pkg::NUM_CLASSES;

	logic [spdtq_pkg::CAP_W-1:0]        cap_q;
	logic [spdtq_pkg::PTR_W-1:0]        head_q [NC];
	logic [spdtq_pkg::PTR_W-1:0]        tail_q [NC];
	logic [spdtq_pkg::CNT_W-1:0]        occ_q  [NC];
	logic [spdtq_pkg::HANDLE_WIDTH-1:0] mem    [NC * spdtq_pkg::FIFO_DEPTH];
	logic [spdtq_pkg::HANDLE_WIDTH-1:0] rdata_q;

	logic                          enq_acc_q, enq_drop_q, deq_valid_q;
	logic [spdtq_pkg::CLASS_W-1:0] deq_class_q;

	logic [spdtq_pkg::CNT_W-1:0]   limit;
	logic                          enq_ok;
	logic                          mem_we;
	logic                          pick_found;
	logic [spdtq_pkg::CLASS_W-1:0] pick_cls;
	logic [spdtq_pkg::ADDR_W-1:0]  waddr, raddr;
	logic [spdtq_pkg::PTR_W-1:0]   tail_nxt, head_nxt;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	// Effective limit: zero or above depth means the full depth
	always_comb begin
		if (cap_q == '0 || int'(cap_q) > spdtq_pkg::FIFO_DEPTH) begin
			limit = spdtq_pkg::CNT_W'(spdtq_pkg::FIFO_DEPTH);
		end else begin
			limit = spdtq_pkg::CNT_W'(cap_q);
		end
	end

	// Drop-tail decision
	assign enq_ok = (int'(queue_class) < NC) && (occ_q[queue_class] < limit);
	assign mem_we = cmd.exec_enq && enq_ok;

	// Lowest-numbered non-empty class wins
	always_comb begin
		pick_found = 1'b0;
		pick_cls   = '0;
		for (int i = NC - 1; i >= 0; i--) begin
			if (occ_q[i] != '0) begin
				pick_found = 1'b1;
				pick_cls   = spdtq_pkg::CLASS_W'(i);
			end
		end
	end

	// Pointer wrap and store addresses
	assign tail_nxt = (int'(tail_q[queue_class]) == spdtq_pkg::FIFO_DEPTH - 1) ? '0
		: tail_q[queue_class] + 1'b1;
	assign head_nxt = (int'(head_q[pick_cls]) == spdtq_pkg::FIFO_DEPTH - 1) ? '0
		: head_q[pick_cls] + 1'b1;
	assign waddr = spdtq_pkg::ADDR_W'(queue_class) * spdtq_pkg::ADDR_W'(spdtq_pkg::FIFO_DEPTH)
		+ spdtq_pkg::ADDR_W'(tail_q[queue_class]);
	assign raddr = spdtq_pkg::ADDR_W'(pick_cls) * spdtq_pkg::ADDR_W'(spdtq_pkg::FIFO_DEPTH)
		+ spdtq_pkg::ADDR_W'(head_q[pick_cls]);

	// Per-class pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else if (mem_we) begin
			tail_q[queue_class] <= tail_nxt;
			occ_q[queue_class]  <= occ_q[queue_class] + 1'b1;
		end else if (cmd.exec_deq && pick_found) begin
			head_q[pick_cls] <= head_nxt;
			occ_q[pick_cls]  <= occ_q[pick_cls] - 1'b1;
		end
	end

	// Packet store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= packet_handle;
		end
		if (cmd.exec_deq) begin
			rdata_q <= mem[raddr];
		end
	end

	// Result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enq_acc_q   <= 1'b0;
			enq_drop_q  <= 1'b0;
			deq_valid_q <= 1'b0;
			deq_class_q <= '0;
		end else if (cmd.exec_enq || cmd.exec_deq) begin
			enq_acc_q   <= cmd.exec_enq && enq_ok;
			enq_drop_q  <= cmd.exec_enq && !enq_ok;
			deq_valid_q <= cmd.exec_deq && pick_found;
			deq_class_q <= (cmd.exec_deq && pick_found) ? pick_cls : '0;
		end
	end

	assign enq_accepted = enq_acc_q;
	assign enq_dropped  = enq_drop_q;
	assign deq_valid    = deq_valid_q;
	assign deq_class    = deq_class_q;
	assign deq_packet   = deq_valid_q ? rdata_q : '0;

	`SPDTQ_ASSERT_ALWAYS(a_enq_flags_exclusive, !(enq_acc_q && enq_drop_q))
	`SPDTQ_ASSERT_ALWAYS(a_deq_excludes_enq, !(deq_valid_q && (enq_acc_q || enq_drop_q)))
	`SPDTQ_ASSERT_SAME(a_write_within_limit, mem_we, occ_q[queue_class] < limit)
	`SPDTQ_ASSERT_ALWAYS(a_class0_bounded, int'(occ_q[0]) <= spdtq_pkg::FIFO_DEPTH)

endmodule
